@@ rtl/tlqe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tlqe_pkg;

  // Register file
  localparam int THICK_W    = 16;
  localparam int VP_W       = 14;
  localparam int COLOR_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THICKNESS = 2'd0,
    REG_VP_WIDTH  = 2'd1,
    REG_VP_HEIGHT = 2'd2,
    REG_COLOR     = 2'd3
  } reg_idx_t;

  localparam logic [THICK_W-1:0] RST_THICKNESS = 16'd256;
  localparam logic [VP_W-1:0]    RST_VP_WIDTH  = 14'd1024;
  localparam logic [VP_W-1:0]    RST_VP_HEIGHT = 14'd768;
  localparam logic [COLOR_W-1:0] RST_COLOR     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [THICK_W-1:0] thickness;
    logic [VP_W-1:0]    vp_width;
    logic [VP_W-1:0]    vp_height;
  } geom_cfg_t;

  // Item kinds on the result channel
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_INDEX  = 1'b1;

  localparam int NUM_VERTS = 4;
  localparam int NUM_ITEMS = 10;
  localparam int CNT_W     = 4;

  // Normal arithmetic
  localparam int SCL_W     = 17;            // magnitudes after range scaling
  localparam int SQ_W      = 2 * SCL_W + 1; // dx^2 + dy^2
  localparam int RAD_SHIFT = 20;
  localparam int LEN_W     = 28;            // root bits
  localparam int RAD_W     = 2 * LEN_W;     // radicand bits
  localparam int NRM_FRAC  = 25;
  localparam int NRM_W     = 16;
  localparam logic [NRM_W-1:0] NRM_ONE = 16'd32768;
  localparam int PROD_W    = 32;            // |n| * thickness
  localparam int OFF_FRAC  = 23;

  // Corner order of the two triangles
  function automatic logic [1:0] quad_corner(input logic [2:0] slot);
    logic [1:0] c;
    case (slot)
      3'd0:    c = 2'd0;
      3'd1:    c = 2'd1;
      3'd2:    c = 2'd2;
      3'd3:    c = 2'd1;
      3'd4:    c = 2'd3;
      3'd5:    c = 2'd2;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/tlqe_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Pipelined digit-by-digit integer square root, one result bit per stage.
module tlqe_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_i,
  input  logic [tlqe_pkg::RAD_W-1:0]  rad_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        vld_o,
  output logic [tlqe_pkg::LEN_W-1:0]  root_o,
  output logic [SIDE_W-1:0]           side_o
);

  localparam int N    = tlqe_pkg::LEN_W;
  localparam int RM_W = N + 2;

  logic                       vld_r  [0:N];
  logic [tlqe_pkg::RAD_W-1:0] rad_r  [0:N];
  logic [SIDE_W-1:0]          side_r [0:N];
  logic [RM_W-1:0]            rem_r  [0:N];
  logic [N-1:0]               root_r [0:N];
  logic [RM_W-1:0]            rem_nxt  [1:N];
  logic [N-1:0]               root_nxt [1:N];

  always_comb begin
    for (int j = 1; j <= N; j++) begin
      logic [RM_W+1:0] shr;
      logic [RM_W+1:0] trial;
      shr   = {rem_r[j-1], rad_r[j-1][tlqe_pkg::RAD_W-1-2*(j-1) -: 2]};
      trial = (RM_W+2)'({root_r[j-1], 2'b01});
      if (shr >= trial) begin
        rem_nxt[j]  = RM_W'(shr - trial);
        root_nxt[j] = {root_r[j-1][N-2:0], 1'b1};
      end else begin
        rem_nxt[j]  = shr[RM_W-1:0];
        root_nxt[j] = {root_r[j-1][N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= N; j++) vld_r[j] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int j = 1; j <= N; j++) vld_r[j] <= vld_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= rad_i;
      side_r[0] <= side_i;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      for (int j = 1; j <= N; j++) begin
        rad_r[j]  <= rad_r[j-1];
        side_r[j] <= side_r[j-1];
        rem_r[j]  <= rem_nxt[j];
        root_r[j] <= root_nxt[j];
      end
    end
  end

  assign vld_o  = vld_r[N];
  assign root_o = root_r[N];
  assign side_o = side_r[N];

endmodule

`default_nettype wire

@@ rtl/tlqe_div2.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Two-lane pipelined restoring divider, one quotient bit per stage.
// ovf_o flags a quotient that does not fit in Q_W bits.
module tlqe_div2 #(
  parameter int NUM_W  = 43,
  parameter int DEN_W  = 28,
  parameter int Q_W    = 16,
  parameter int SIDE_W = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   vld_i,
  input  logic [1:0][NUM_W-1:0]  num_i,
  input  logic [1:0][DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic                   vld_o,
  output logic [1:0][Q_W-1:0]    quot_o,
  output logic [1:0]             ovf_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic              vld_r  [0:Q_W];
  logic [SIDE_W-1:0] side_r [0:Q_W];
  logic [W-1:0]      rem_r  [0:1][0:Q_W];
  logic [DEN_W-1:0]  den_r  [0:1][0:Q_W];
  logic [Q_W-1:0]    q_r    [0:1][0:Q_W];
  logic              ovf_r  [0:1][0:Q_W];
  logic [W-1:0]      rem_nxt [0:1][1:Q_W];
  logic [Q_W-1:0]    q_nxt   [0:1][1:Q_W];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int j = 1; j <= Q_W; j++) begin
        logic [W-1:0] trial;
        trial = W'(den_r[l][j-1]) << (Q_W - j);
        q_nxt[l][j] = q_r[l][j-1];
        if (rem_r[l][j-1] >= trial) begin
          rem_nxt[l][j]         = rem_r[l][j-1] - trial;
          q_nxt[l][j][Q_W - j]  = 1'b1;
        end else begin
          rem_nxt[l][j] = rem_r[l][j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= Q_W; j++) vld_r[j] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int j = 1; j <= Q_W; j++) vld_r[j] <= vld_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_i;
      for (int j = 1; j <= Q_W; j++) side_r[j] <= side_r[j-1];
      for (int l = 0; l < 2; l++) begin
        rem_r[l][0] <= W'(num_i[l]);
        den_r[l][0] <= den_i[l];
        q_r[l][0]   <= '0;
        ovf_r[l][0] <= W'(num_i[l]) >= (W'(den_i[l]) << Q_W);
        for (int j = 1; j <= Q_W; j++) begin
          rem_r[l][j] <= rem_nxt[l][j];
          den_r[l][j] <= den_r[l][j-1];
          q_r[l][j]   <= q_nxt[l][j];
          ovf_r[l][j] <= ovf_r[l][j-1];
        end
      end
    end
  end

  assign vld_o     = vld_r[Q_W];
  assign side_o    = side_r[Q_W];
  assign quot_o[0] = q_r[0][Q_W];
  assign quot_o[1] = q_r[1][Q_W];
  assign ovf_o[0]  = ovf_r[0][Q_W];
  assign ovf_o[1]  = ovf_r[1][Q_W];

endmodule

`default_nettype wire

@@ rtl/tlqe_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Front end: takes segments, orders them and computes the four corners.
// Whole pipe moves together; it holds only when the last stage can't push.
module tlqe_front #(
  parameter int CW    = 16,
  parameter int VIW   = 16,
  parameter int IN_W  = 80,
  parameter int ENT_W = 8 * CW + VIW
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [IN_W-1:0]     in_data,
  input  tlqe_pkg::geom_cfg_t cfg,
  input  logic                q_full,
  output logic                q_push,
  output logic [ENT_W-1:0]    q_data
);

  localparam int MW       = CW + 1;
  localparam int SHW      = $clog2(MW + 1);
  localparam longint VERT_LIM = ((64'sd1 <<< (CW - 2)) + 64'sd9999) / 64'sd10000;
  localparam int SIDE0_W  = 4 * CW + VIW;
  localparam int SCL_W    = tlqe_pkg::SCL_W;
  localparam int SQS_W    = SIDE0_W + 2 + 2 * SCL_W;
  localparam int NN_W     = SCL_W + tlqe_pkg::NRM_FRAC + 1;
  localparam int LEN_W    = tlqe_pkg::LEN_W;
  localparam int NRM_W    = tlqe_pkg::NRM_W;
  localparam int PROD_W   = tlqe_pkg::PROD_W;
  localparam int NO_W     = CW + 31;
  localparam int OD_W     = tlqe_pkg::VP_W + tlqe_pkg::OFF_FRAC;
  localparam int OQ_W     = CW + 1;
  localparam int E_W      = CW + 3;
  localparam logic signed [E_W-1:0] CMAX = E_W'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [E_W-1:0] CMIN = E_W'(-(64'sd1 <<< (CW - 1)));

  function automatic logic [CW-1:0] sat(input logic signed [E_W-1:0] v);
    logic [CW-1:0] r;
    if (v > CMAX)      r = CMAX[CW-1:0];
    else if (v < CMIN) r = CMIN[CW-1:0];
    else               r = v[CW-1:0];
    return r;
  endfunction

  logic adv;
  logic vf_r;

  assign adv      = !vf_r || !q_full;
  assign in_ready = adv;
  assign q_push   = vf_r && !q_full;

  // ---- stage 0: endpoint ordering
  logic signed [CW-1:0] ibx, iby, iex, iey;
  logic [VIW-1:0]       ibase;
  logic                 swap;
  logic                 v0_r;
  logic [SIDE0_W-1:0]   s0_r;

  assign ibx   = in_data[0 +: CW];
  assign iby   = in_data[CW +: CW];
  assign iex   = in_data[2*CW +: CW];
  assign iey   = in_data[3*CW +: CW];
  assign ibase = in_data[4*CW +: VIW];
  assign swap  = (ibx > iex) || ((ibx == iex) && (iby < iey));

  // ---- stage 1: differences
  logic signed [CW-1:0] bx0, by0, ex0, ey0;
  logic [MW-1:0]        dx0, dys0, dym0;
  logic                 v1_r, vert1_r, neg1_r;
  logic [MW-1:0]        dx1_r, dy1_r;
  logic [SIDE0_W-1:0]   s1_r;

  assign bx0  = s0_r[0 +: CW];
  assign by0  = s0_r[CW +: CW];
  assign ex0  = s0_r[2*CW +: CW];
  assign ey0  = s0_r[3*CW +: CW];
  assign dx0  = {ex0[CW-1], ex0} - {bx0[CW-1], bx0};
  assign dys0 = {ey0[CW-1], ey0} - {by0[CW-1], by0};
  assign dym0 = dys0[MW-1] ? (~dys0 + 1'b1) : dys0;

  // ---- stage 2: scale both magnitudes below 2^17
  logic [MW-1:0]        mor1;
  logic [SHW-1:0]       sh1;
  logic [MW+SCL_W-1:0]  tdx1, tdy1;
  logic                 v2_r, vert2_r, neg2_r;
  logic [SCL_W-1:0]     dxs2_r, dys2_r;
  logic [SIDE0_W-1:0]   s2_r;

  assign mor1 = dx1_r | dy1_r;
  always_comb begin
    sh1 = '0;
    for (int k = 0; k < MW; k++) begin
      if (mor1[k] && (k >= SCL_W)) sh1 = SHW'(k - SCL_W + 1);
    end
  end
  assign tdx1 = (MW+SCL_W)'(dx1_r) >> sh1;
  assign tdy1 = (MW+SCL_W)'(dy1_r) >> sh1;

  // ---- stage 3: sum of squares
  logic                 v3_r, vert3_r, neg3_r;
  logic [tlqe_pkg::SQ_W-1:0] sq3_r;
  logic [SCL_W-1:0]     dxs3_r, dys3_r;
  logic [SIDE0_W-1:0]   s3_r;

  // ---- root
  logic                 sq_vld;
  logic [LEN_W-1:0]     sq_len;
  logic [SQS_W-1:0]     sq_side;

  tlqe_sqrt #(.SIDE_W(SQS_W)) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .vld_i  (v3_r),
    .rad_i  ({1'b0, sq3_r, {tlqe_pkg::RAD_SHIFT{1'b0}}}),
    .side_i ({dys3_r, dxs3_r, neg3_r, vert3_r, s3_r}),
    .vld_o  (sq_vld),
    .root_o (sq_len),
    .side_o (sq_side)
  );

  // ---- stage 4: rounded numerators for the normal
  logic [SCL_W-1:0]     sq_dxs, sq_dys;
  logic                 v4_r;
  logic [NN_W-1:0]      na4_r, nb4_r;
  logic [LEN_W-1:0]     len4_r;
  logic [SIDE0_W+1:0]   s4_r;

  assign sq_dxs = sq_side[SIDE0_W+2 +: SCL_W];
  assign sq_dys = sq_side[SIDE0_W+2+SCL_W +: SCL_W];

  logic                   nd_vld;
  logic [1:0][NRM_W-1:0]  nd_q;
  logic [1:0]             nd_ovf;
  logic [SIDE0_W+1:0]     nd_side;

  tlqe_div2 #(
    .NUM_W  (NN_W),
    .DEN_W  (LEN_W),
    .Q_W    (NRM_W),
    .SIDE_W (SIDE0_W + 2)
  ) u_nrm_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .vld_i  (v4_r),
    .num_i  ({nb4_r, na4_r}),
    .den_i  ({len4_r, len4_r}),
    .side_i (s4_r),
    .vld_o  (nd_vld),
    .quot_o (nd_q),
    .ovf_o  (nd_ovf),
    .side_o (nd_side)
  );

  // ---- stage 5: normal magnitudes times thickness
  logic                 nd_vert, nd_neg;
  logic [NRM_W-1:0]     mag_a, mag_b, nmx, nmy;
  logic                 v5_r, sx5_r;
  logic [PROD_W-1:0]    px5_r, py5_r;
  logic [SIDE0_W-1:0]   s5_r;

  assign nd_vert = nd_side[SIDE0_W];
  assign nd_neg  = nd_side[SIDE0_W+1];
  assign mag_a   = (nd_ovf[0] || (nd_q[0] > tlqe_pkg::NRM_ONE)) ? tlqe_pkg::NRM_ONE : nd_q[0];
  assign mag_b   = (nd_ovf[1] || (nd_q[1] > tlqe_pkg::NRM_ONE)) ? tlqe_pkg::NRM_ONE : nd_q[1];
  assign nmx     = nd_vert ? tlqe_pkg::NRM_ONE : mag_a;
  assign nmy     = nd_vert ? '0 : mag_b;

  // ---- stage 6: offset numerators and divisors
  logic [tlqe_pkg::VP_W-1:0] vpx, vpy;
  logic                 v6_r, sx6_r;
  logic [NO_W-1:0]      nx6_r, ny6_r;
  logic [OD_W-1:0]      dx6_r, dy6_r;
  logic [SIDE0_W-1:0]   s6_r;

  assign vpx = (cfg.vp_width == '0)  ? tlqe_pkg::VP_W'(1) : cfg.vp_width;
  assign vpy = (cfg.vp_height == '0) ? tlqe_pkg::VP_W'(1) : cfg.vp_height;

  logic                  od_vld;
  logic [1:0][OQ_W-1:0]  od_q;
  logic [1:0]            od_ovf;
  logic [SIDE0_W:0]      od_side;

  tlqe_div2 #(
    .NUM_W  (NO_W),
    .DEN_W  (OD_W),
    .Q_W    (OQ_W),
    .SIDE_W (SIDE0_W + 1)
  ) u_off_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .vld_i  (v6_r),
    .num_i  ({ny6_r, nx6_r}),
    .den_i  ({dy6_r, dx6_r}),
    .side_i ({sx6_r, s6_r}),
    .vld_o  (od_vld),
    .quot_o (od_q),
    .ovf_o  (od_ovf),
    .side_o (od_side)
  );

  // ---- stage 7: corners with saturation
  logic [OQ_W-1:0]      mx, my;
  logic signed [E_W-1:0] oxe, oye, mxe;
  logic signed [CW-1:0] fbx, fby, fex, fey;
  logic signed [E_W-1:0] bxe, bye, exe, eye;
  logic [VIW-1:0]       fbase;
  logic [ENT_W-1:0]     ent_r;

  assign mx    = od_ovf[0] ? '1 : od_q[0];
  assign my    = od_ovf[1] ? '1 : od_q[1];
  assign mxe   = $signed({2'b00, mx});
  assign oxe   = od_side[SIDE0_W] ? -mxe : mxe;
  assign oye   = $signed({2'b00, my});
  assign fbx   = od_side[0 +: CW];
  assign fby   = od_side[CW +: CW];
  assign fex   = od_side[2*CW +: CW];
  assign fey   = od_side[3*CW +: CW];
  assign fbase = od_side[4*CW +: VIW];
  assign bxe   = E_W'(fbx);
  assign bye   = E_W'(fby);
  assign exe   = E_W'(fex);
  assign eye   = E_W'(fey);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      vf_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= sq_vld;
      v5_r <= nd_vld;
      v6_r <= v5_r;
      vf_r <= od_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r <= swap ? {ibase, iby, ibx, iey, iex} : {ibase, iey, iex, iby, ibx};

      dx1_r   <= dx0;
      dy1_r   <= dym0;
      neg1_r  <= !dys0[MW-1] && (dys0 != '0);
      vert1_r <= dx0 < MW'(VERT_LIM);
      s1_r    <= s0_r;

      dxs2_r  <= tdx1[SCL_W-1:0];
      dys2_r  <= tdy1[SCL_W-1:0];
      neg2_r  <= neg1_r;
      vert2_r <= vert1_r;
      s2_r    <= s1_r;

      sq3_r   <= tlqe_pkg::SQ_W'(dxs2_r * dxs2_r) + tlqe_pkg::SQ_W'(dys2_r * dys2_r);
      dxs3_r  <= dxs2_r;
      dys3_r  <= dys2_r;
      neg3_r  <= neg2_r;
      vert3_r <= vert2_r;
      s3_r    <= s2_r;

      na4_r  <= NN_W'({sq_dys, {tlqe_pkg::NRM_FRAC{1'b0}}}) + NN_W'(sq_len >> 1);
      nb4_r  <= NN_W'({sq_dxs, {tlqe_pkg::NRM_FRAC{1'b0}}}) + NN_W'(sq_len >> 1);
      len4_r <= sq_len;
      s4_r   <= sq_side[SIDE0_W+1:0];

      px5_r <= PROD_W'(nmx) * PROD_W'(cfg.thickness);
      py5_r <= PROD_W'(nmy) * PROD_W'(cfg.thickness);
      sx5_r <= nd_neg && !nd_vert;
      s5_r  <= nd_side[SIDE0_W-1:0];

      nx6_r <= (NO_W'(px5_r) << (CW - 2)) + (NO_W'(vpx) << (tlqe_pkg::OFF_FRAC - 1));
      ny6_r <= (NO_W'(py5_r) << (CW - 2)) + (NO_W'(vpy) << (tlqe_pkg::OFF_FRAC - 1));
      dx6_r <= {vpx, {tlqe_pkg::OFF_FRAC{1'b0}}};
      dy6_r <= {vpy, {tlqe_pkg::OFF_FRAC{1'b0}}};
      sx6_r <= sx5_r;
      s6_r  <= s5_r;

      ent_r <= {fbase,
                sat(eye + oye), sat(eye - oye), sat(bye + oye), sat(bye - oye),
                sat(exe + oxe), sat(exe - oxe), sat(bxe + oxe), sat(bxe - oxe)};
    end
  end

  assign q_data = ent_r;

endmodule

`default_nettype wire

@@ rtl/tlqe_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Two-entry queue between front and back.
module tlqe_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  output logic         valid,
  input  logic         pop,
  output logic [W-1:0] rdata
);

  logic [W-1:0] mem_r [0:1];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  assign full  = cnt_r == 2'd2;
  assign valid = cnt_r != 2'd0;
  assign rdata = mem_r[rp_r];

endmodule

`default_nettype wire

@@ rtl/tlqe_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Back end: plays out four vertex words and six index words per entry.
module tlqe_back #(
  parameter int CW    = 16,
  parameter int VIW   = 16,
  parameter int ENT_W = 8 * CW + VIW,
  parameter int OUT_W = 80
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  logic [ENT_W-1:0]              q_data,
  input  logic [tlqe_pkg::COLOR_W-1:0]  color,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_W-1:0]              out_tdata,
  output logic                          out_tuser,
  output logic                          out_tlast
);

  localparam int CNT_W = tlqe_pkg::CNT_W;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(tlqe_pkg::NUM_ITEMS - 1);
  localparam logic [CNT_W-1:0] NV_CNT   = CNT_W'(tlqe_pkg::NUM_VERTS);

  logic [ENT_W-1:0]  cur_r;
  logic              cur_v_r, cur_v_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ovld_r, ovld_nxt;
  logic [CW-1:0]     px_r, py_r;
  logic [tlqe_pkg::COLOR_W-1:0] col_r;
  logic [VIW-1:0]    idx_r;
  logic              kind_r, last_r;

  logic              slot_free, emit, done;
  logic [1:0]        corner;
  logic [VIW-1:0]    base;
  logic [CW-1:0]     vx, vy;

  assign slot_free = !ovld_r || out_tready;
  assign emit      = slot_free && cur_v_r;
  assign done      = emit && (cnt_r == LAST_CNT);
  assign q_pop     = q_valid && (!cur_v_r || done);

  assign corner = tlqe_pkg::quad_corner(3'(cnt_r - NV_CNT));
  assign base   = cur_r[8*CW +: VIW];
  assign vx     = cur_r[cnt_r[1:0]*CW +: CW];
  assign vy     = cur_r[(4 + cnt_r[1:0])*CW +: CW];

  always_comb begin
    cur_v_nxt = cur_v_r;
    cnt_nxt   = cnt_r;
    ovld_nxt  = ovld_r;
    if (slot_free) ovld_nxt = 1'b0;
    if (emit) begin
      ovld_nxt = 1'b1;
      cnt_nxt  = cnt_r + 1'b1;
    end
    if (done) cur_v_nxt = 1'b0;
    if (q_pop) begin
      cur_v_nxt = 1'b1;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      cnt_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
      cnt_r   <= cnt_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_data;
    if (emit) begin
      last_r <= cnt_r == LAST_CNT;
      if (cnt_r < NV_CNT) begin
        kind_r <= tlqe_pkg::KIND_VERTEX;
        px_r   <= vx;
        py_r   <= vy;
        col_r  <= color;
        idx_r  <= '0;
      end else begin
        kind_r <= tlqe_pkg::KIND_INDEX;
        px_r   <= '0;
        py_r   <= '0;
        col_r  <= '0;
        idx_r  <= base + VIW'(corner);
      end
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = OUT_W'({idx_r, col_r, py_r, px_r});
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

@@ rtl/thick_line_quad_expander.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Thick line quad expander.
// Input stream: one word per segment (two endpoints in Q1.14 device
// coordinates plus the base vertex number). Output stream: ten words per
// segment, four vertex words (tuser low) then six index words (tuser high),
// tlast on the tenth.
// The front end is a fully pipelined datapath: ordering and scaling, a
// 28-stage square root, a 16-stage divider for the unit normal and a
// (COORD_WIDTH+1)-stage divider for the offsets. It takes one segment a
// cycle unless held; a two-entry queue decouples it from the back end.
// The segment rate is set by the output channel, which moves one word a
// cycle while the receiver is ready.
// Output words sit in a register; when the receiver stalls the back end
// holds, the queue fills and then the whole front pipe freezes, with
// in_tready low. Nothing is lost or repeated.
// Reset (synchronous, rst_n low) empties the pipe and queue and loads the
// register defaults. The config port is always ready; write only while idle.
module thick_line_quad_expander #(
  parameter int COORD_WIDTH        = 16,
  parameter int VERTEX_INDEX_WIDTH = 16,
  localparam int IN_W  = ((4 * COORD_WIDTH + VERTEX_INDEX_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_WIDTH + 32 + VERTEX_INDEX_WIDTH + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // begin_x, begin_y, end_x, end_y, base_vertex
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_W-1:0]                   in_tdata,
  // pos_x, pos_y, vertex_color, index_value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [OUT_W-1:0]                  out_tdata,
  // item_kind
  output logic                              out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tlqe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tlqe_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int ENT_W = 8 * COORD_WIDTH + VERTEX_INDEX_WIDTH;

  tlqe_pkg::geom_cfg_t          geom_r;
  logic [tlqe_pkg::COLOR_W-1:0] color_r;

  logic             q_push, q_full, q_valid, q_pop;
  logic [ENT_W-1:0] q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  // Register file; unknown indexes cannot occur with a 2-bit index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r.thickness <= tlqe_pkg::RST_THICKNESS;
      geom_r.vp_width  <= tlqe_pkg::RST_VP_WIDTH;
      geom_r.vp_height <= tlqe_pkg::RST_VP_HEIGHT;
      color_r          <= tlqe_pkg::RST_COLOR;
    end else if (cfg_valid && cfg_ready) begin
      case (tlqe_pkg::reg_idx_t'(cfg_index))
        tlqe_pkg::REG_THICKNESS: geom_r.thickness <= cfg_data[tlqe_pkg::THICK_W-1:0];
        tlqe_pkg::REG_VP_WIDTH:  geom_r.vp_width  <= cfg_data[tlqe_pkg::VP_W-1:0];
        tlqe_pkg::REG_VP_HEIGHT: geom_r.vp_height <= cfg_data[tlqe_pkg::VP_W-1:0];
        tlqe_pkg::REG_COLOR:     color_r          <= cfg_data[tlqe_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  tlqe_front #(
    .CW    (COORD_WIDTH),
    .VIW   (VERTEX_INDEX_WIDTH),
    .IN_W  (IN_W),
    .ENT_W (ENT_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_tdata),
    .cfg      (geom_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  tlqe_queue #(.W(ENT_W)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .valid (q_valid),
    .pop   (q_pop),
    .rdata (q_rdata)
  );

  tlqe_back #(
    .CW    (COORD_WIDTH),
    .VIW   (VERTEX_INDEX_WIDTH),
    .ENT_W (ENT_W),
    .OUT_W (OUT_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_data     (q_rdata),
    .color      (color_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int CW    = 16;
  localparam int VW    = 16;
  localparam int IN_W  = 80;
  localparam int OUT_W = 80;
  localparam int LATENCY   = 120;
  localparam int MAX_CYCLES = 400000;

  typedef struct packed {
    logic          kind;
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [31:0]   color;
    logic [VW-1:0] idx;
    logic          last;
  } quad_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic out_tuser, out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tlqe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tlqe_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  thick_line_quad_expander DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Shadow register file for the predictor
  logic [15:0] thick_q = tlqe_pkg::RST_THICKNESS;
  logic [13:0] vpw_q   = tlqe_pkg::RST_VP_WIDTH;
  logic [13:0] vph_q   = tlqe_pkg::RST_VP_HEIGHT;
  logic [31:0] color_q = tlqe_pkg::RST_COLOR;

  quad_word_t quad_q[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 1'b0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic longint round_div(input longint num, input longint den);
    longint m, q;
    m = (num < 0) ? -num : num;
    q = (m + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint int_sqrt(input longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint sat_coord(input longint v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  function automatic longint clamp_nrm(input longint v);
    if (v < -32768) return -32768;
    if (v > 32768) return 32768;
    return v;
  endfunction

  // Expand one segment into the ten expected words
  task automatic predict_quad(input logic [IN_W-1:0] w);
    longint bx, by, ex, ey, t, dx, dys, dy, len, sdy, nx, ny, ox, oy, vw, vh;
    longint px[4], py[4];
    logic [VW-1:0] base;
    logic [2:0] pat[6];
    quad_word_t q;
    pat = '{3'd0, 3'd1, 3'd2, 3'd1, 3'd3, 3'd2};
    bx = $signed(w[15:0]);  by = $signed(w[31:16]);
    ex = $signed(w[47:32]); ey = $signed(w[63:48]);
    base = w[79:64];
    if (bx > ex || (bx == ex && by < ey)) begin
      t = bx; bx = ex; ex = t;
      t = by; by = ey; ey = t;
    end
    dx = ex - bx;
    dys = ey - by;
    dy = (dys < 0) ? -dys : dys;
    if (dx * 10000 < (64'sd1 <<< (CW - 2))) begin
      nx = 32768; ny = 0;
    end else begin
      while (dx >= (1 << 17) || dy >= (1 << 17)) begin
        dx = dx >>> 1; dy = dy >>> 1;
      end
      len = int_sqrt((dx * dx + dy * dy) <<< 20);
      if (len == 0) len = 1;
      sdy = (dys < 0) ? -dy : dy;
      nx = clamp_nrm(round_div(-sdy * (64'sd1 <<< 25), len));
      ny = clamp_nrm(round_div(dx * (64'sd1 <<< 25), len));
    end
    vw = (vpw_q == 0) ? 1 : vpw_q;
    vh = (vph_q == 0) ? 1 : vph_q;
    ox = round_div(nx * longint'(thick_q) * (64'sd1 <<< (CW - 2)), (64'sd1 <<< 23) * vw);
    oy = round_div(ny * longint'(thick_q) * (64'sd1 <<< (CW - 2)), (64'sd1 <<< 23) * vh);
    px[0] = bx - ox; py[0] = by - oy;
    px[1] = bx + ox; py[1] = by + oy;
    px[2] = ex - ox; py[2] = ey - oy;
    px[3] = ex + ox; py[3] = ey + oy;
    for (int k = 0; k < 10; k++) begin
      q = '0;
      if (k < 4) begin
        q.kind  = tlqe_pkg::KIND_VERTEX;
        q.px    = CW'(sat_coord(px[k]));
        q.py    = CW'(sat_coord(py[k]));
        q.color = color_q;
      end else begin
        q.kind = tlqe_pkg::KIND_INDEX;
        q.idx  = base + pat[k - 4];
      end
      q.last = (k == 9);
      quad_q.push_back(q);
    end
  endtask

  // Result checker: runs on every accepted output word
  always @(posedge clk) begin
    quad_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (quad_q.size() == 0) begin
        report_mismatch("unexpected word", longint'(out_tdata[63:0]), 0);
      end else begin
        want = quad_q.pop_front();
        if (out_tuser !== want.kind) report_mismatch("kind", out_tuser, want.kind);
        if (out_tdata[15:0] !== want.px) report_mismatch("pos_x", out_tdata[15:0], want.px);
        if (out_tdata[31:16] !== want.py) report_mismatch("pos_y", out_tdata[31:16], want.py);
        if (out_tdata[63:32] !== want.color)
          report_mismatch("colour", out_tdata[63:32], want.color);
        if (out_tdata[79:64] !== want.idx) report_mismatch("index", out_tdata[79:64], want.idx);
        if (out_tlast !== want.last) report_mismatch("last", out_tlast, want.last);
      end
    end
  end

  // Receiver backpressure
  always @(posedge clk) begin
    if (hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // tvalid stays high after a word is taken so words can follow back to back
  task automatic send_segment(input logic [IN_W-1:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    predict_quad(w);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (quad_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // Idle-only register write; shadow updated at the same time
  task automatic write_reg(input tlqe_pkg::reg_idx_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      tlqe_pkg::REG_THICKNESS: thick_q = val[15:0];
      tlqe_pkg::REG_VP_WIDTH:  vpw_q   = val[13:0];
      tlqe_pkg::REG_VP_HEIGHT: vph_q   = val[13:0];
      tlqe_pkg::REG_COLOR:     color_q = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [IN_W-1:0] pack_seg(input logic [15:0] bx, by, ex, ey, base);
    return {base, ey, ex, by, bx};
  endfunction

  function automatic logic [15:0] rand_coord;
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(255) - 128);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [IN_W-1:0] rand_seg;
    logic [15:0] bx, by, ex, ey;
    bx = rand_coord(); by = rand_coord();
    ey = rand_coord();
    // a fair share of vertical and near-vertical segments
    case ($urandom_range(4))
      0: ex = bx;
      1: ex = 16'(bx + $urandom_range(3));
      default: ex = rand_coord();
    endcase
    return pack_seg(bx, by, ex, ey, 16'($urandom));
  endfunction

  task automatic test_directed;
    send_segment(pack_seg(16'h0000, 16'h0000, 16'h2000, 16'h1000, 16'd0));
    send_segment(pack_seg(16'h2000, 16'h1000, 16'h0000, 16'h0000, 16'd4));
    send_segment(pack_seg(16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'd8));   // identical ends
    send_segment(pack_seg(16'h0100, 16'hF000, 16'h0100, 16'h1000, 16'd12)); // equal x
    send_segment(pack_seg(16'h0100, 16'h0000, 16'h0101, 16'h3000, 16'd16)); // nearly vertical
    send_segment(pack_seg(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'hFFFC));
    send_segment(pack_seg(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF)); // index wrap
    send_segment(pack_seg(16'h7FFF, 16'h7FFF, 16'h7FF0, 16'h8000, 16'h8000));
    send_segment(pack_seg(16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h1234)); // horizontal
    send_segment(pack_seg(16'hC000, 16'h0000, 16'h3FFF, 16'h0001, 16'hAAAA));
    drain();
  endtask

  task automatic test_config_extremes;
    write_reg(tlqe_pkg::REG_THICKNESS, 32'hFFFF);
    write_reg(tlqe_pkg::REG_VP_WIDTH, 32'd1);
    write_reg(tlqe_pkg::REG_VP_HEIGHT, 32'd1);
    write_reg(tlqe_pkg::REG_COLOR, 32'h0000_0000);
    send_segment(pack_seg(16'h0000, 16'h0000, 16'h2000, 16'h2000, 16'd1));
    send_segment(pack_seg(16'h7000, 16'h9000, 16'h7000, 16'h7000, 16'd2));
    drain();
    write_reg(tlqe_pkg::REG_THICKNESS, 32'h0000);
    write_reg(tlqe_pkg::REG_VP_WIDTH, 32'd0);   // zero viewport acts as one
    write_reg(tlqe_pkg::REG_VP_HEIGHT, 32'd8192);
    write_reg(tlqe_pkg::REG_COLOR, 32'hA5C3_5A3C);
    send_segment(pack_seg(16'h1000, 16'h2000, 16'h3000, 16'h0400, 16'd3));
    drain();
    write_reg(tlqe_pkg::REG_THICKNESS, 32'h0800);
    write_reg(tlqe_pkg::REG_VP_WIDTH, 32'h3FFF);
    write_reg(tlqe_pkg::REG_VP_HEIGHT, 32'd0);
    send_segment(pack_seg(16'hF000, 16'h2000, 16'h3000, 16'hE000, 16'd7));
    send_segment(pack_seg(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd9));
    drain();
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send_segment(rand_seg());
    drain();
  endtask

  task automatic test_reconfigure;
    write_reg(tlqe_pkg::REG_THICKNESS, $urandom);
    write_reg(tlqe_pkg::REG_VP_WIDTH, $urandom_range(8192, 1));
    write_reg(tlqe_pkg::REG_VP_HEIGHT, $urandom_range(8192, 1));
    write_reg(tlqe_pkg::REG_COLOR, $urandom);
  endtask

  // Receiver stalls long while the sender keeps offering; more segments than
  // the pipe, queue and back end can hold, so the input backs up
  task automatic test_backpressure;
    hold_off = 1'b1;
    fork
      begin
        for (int i = 0; i < 80; i++) send_segment(rand_seg());
      end
      begin
        int held;
        held = 0;
        while (held < 300) begin
          @(posedge clk);
          held++;
        end
        hold_off = 1'b0;
      end
    join
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 35; recv_idle_pct = 58;
    test_directed();
    test_config_extremes();
    test_reconfigure();
    test_random(10);
    send_idle_pct = 58; recv_idle_pct = 35;
    test_reconfigure();
    test_random(10);
    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(tlqe_pkg::REG_THICKNESS, 32'(tlqe_pkg::RST_THICKNESS));
    write_reg(tlqe_pkg::REG_VP_WIDTH, 32'(tlqe_pkg::RST_VP_WIDTH));
    write_reg(tlqe_pkg::REG_VP_HEIGHT, 32'(tlqe_pkg::RST_VP_HEIGHT));
    write_reg(tlqe_pkg::REG_COLOR, tlqe_pkg::RST_COLOR);
    test_backpressure();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
